FILE: hw/rtl/assert_macros.svh
// Concurrent assertion helpers; the enclosing module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle.
`define ASSERT_NOW(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ppr_pkg.sv
package ppr_pkg;

    localparam int ElemW = 4;
    localparam int RankW = 32;

    typedef struct packed {
        logic [ElemW-1:0] element_value;
        logic             is_last;
    } ppr_elem_t;

    typedef struct packed {
        logic [RankW-1:0] perm_rank;
        logic             length_error;
    } ppr_result_t;

endpackage

FILE: hw/rtl/ppr_stream_if.sv
interface ppr_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/ppr_rank_core.sv
module ppr_rank_core #(
    parameter int UNIVERSE_SIZE = 16,
    parameter int MAX_LENGTH    = 9
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  ppr_pkg::ppr_elem_t  item,
    output ppr_pkg::ppr_result_t result
);

    localparam int LenLimit = (MAX_LENGTH < UNIVERSE_SIZE) ? MAX_LENGTH : UNIVERSE_SIZE;
    localparam int PosW     = $clog2(LenLimit + 1);
    localparam int FactW    = $clog2(UNIVERSE_SIZE + 1);
    localparam int CntW     = $clog2(UNIVERSE_SIZE + 1);

    logic [UNIVERSE_SIZE-1:0]  used_mask_reg, used_mask_next;
    logic [ppr_pkg::RankW-1:0] rank_reg, rank_next;
    logic [PosW-1:0]           pos_reg, pos_next;
    logic                      overflow_reg, overflow_next;

    logic [UNIVERSE_SIZE-1:0]  below;
    logic [UNIVERSE_SIZE-1:0]  hit;
    logic [CntW-1:0]           smaller_free;
    logic [FactW-1:0]          factor;
    logic [ppr_pkg::RankW-1:0] product;
    logic                      at_limit;

    // Values below the element; an element past the universe sees every value below it.
    always_comb
    begin
        for (int b = 0; b < UNIVERSE_SIZE; b++)
        begin
            below[b] = ppr_pkg::ElemW'(b) < item.element_value;
            hit[b]   = ppr_pkg::ElemW'(b) == item.element_value;
        end
    end

    assign smaller_free = CntW'($countones(below & ~used_mask_reg));
    assign factor       = FactW'(UNIVERSE_SIZE) - FactW'(pos_reg);
    assign product      = rank_reg * {{(ppr_pkg::RankW-FactW){1'b0}}, factor};
    assign at_limit     = pos_reg >= PosW'(LenLimit);

    always_comb
    begin
        used_mask_next = used_mask_reg;
        rank_next      = rank_reg;
        pos_next       = pos_reg;
        overflow_next  = overflow_reg;
        if (at_limit)
        begin
            overflow_next = 1'b1;
        end
        else
        begin
            rank_next      = product + {{(ppr_pkg::RankW-CntW){1'b0}}, smaller_free};
            used_mask_next = used_mask_reg | hit;
            pos_next       = pos_reg + PosW'(1);
        end
    end

    always_comb
    begin
        result.length_error = overflow_next;
        result.perm_rank    = overflow_next ? '0 : rank_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_mask_reg <= '0;
            rank_reg      <= '0;
            pos_reg       <= '0;
            overflow_reg  <= 1'b0;
        end
        else if (step)
        begin
            // Drop all sequence state once the last element is taken.
            if (item.is_last)
            begin
                used_mask_reg <= '0;
                rank_reg      <= '0;
                pos_reg       <= '0;
                overflow_reg  <= 1'b0;
            end
            else
            begin
                used_mask_reg <= used_mask_next;
                rank_reg      <= rank_next;
                pos_reg       <= pos_next;
                overflow_reg  <= overflow_next;
            end
        end
    end

endmodule

FILE: hw/rtl/partial_permutation_ranker.sv
// Ranks a partial permutation of distinct values from 0..UNIVERSE_SIZE-1, one value per
// request, and returns its rank when the request flagged is_last arrives. Sequences longer
// than min(MAX_LENGTH, UNIVERSE_SIZE) return rank 0 with length_error set. One element is
// taken every clock while nothing is held back; the rank passes the input register, then the
// result register before it is presented. A rank the sink has not yet taken holds back only
// the next last element. The rate is set by the rank update loop, one multiply-add of the
// running rank by a factor of at most UNIVERSE_SIZE per clock.
`include "assert_macros.svh"

module partial_permutation_ranker #(
    parameter int UNIVERSE_SIZE = 16,
    parameter int MAX_LENGTH    = 9
) (
    input logic         clk,
    input logic         rst_n,
    ppr_stream_if.sink   elements,
    ppr_stream_if.source ranks
);

    logic                 in_valid_reg;
    ppr_pkg::ppr_elem_t   item_reg;
    logic                 out_valid_reg, out_valid_next;
    ppr_pkg::ppr_result_t result_reg;
    ppr_pkg::ppr_result_t step_result;
    logic                 advance;

    // Advance the held element unless its result would overwrite a stalled one.
    assign advance        = in_valid_reg && (!item_reg.is_last || !out_valid_reg || ranks.ready);
    assign elements.ready = !in_valid_reg || advance;

    ppr_rank_core #(
        .UNIVERSE_SIZE (UNIVERSE_SIZE),
        .MAX_LENGTH    (MAX_LENGTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (elements.ready)
        begin
            in_valid_reg <= elements.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elements.ready && elements.valid)
        begin
            item_reg <= elements.payload;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !ranks.ready;
        if (advance && item_reg.is_last)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_reg.is_last)
        begin
            result_reg <= step_result;
        end
    end

    assign ranks.valid   = out_valid_reg;
    assign ranks.payload = result_reg;

    `ASSERT_NOW(a_error_rank_zero,
        !(ranks.valid && ranks.payload.length_error) || (ranks.payload.perm_rank == '0),
        "length error reported with nonzero rank")

    `ASSERT_NEXT(a_last_yields_result, advance && item_reg.is_last, ranks.valid,
        "last element did not produce a result")

    `ASSERT_NEXT(a_held_item_stable, in_valid_reg && !advance,
        in_valid_reg && $stable(item_reg), "held element lost or changed while stalled")

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int UNIVERSE    = 16;
    localparam int MAX_LEN     = 9;
    localparam int LEN_LIMIT   = (MAX_LEN < UNIVERSE) ? MAX_LEN : UNIVERSE;
    localparam int PHASE_ITEMS = 450;

    typedef enum int {
        SEQ_PERM,
        SEQ_OVERLONG,
        SEQ_NOISE
    } seq_kind_e;

    logic clk;
    logic rst_n;

    ppr_stream_if #(.payload_t(ppr_pkg::ppr_elem_t))   elem_if ();
    ppr_stream_if #(.payload_t(ppr_pkg::ppr_result_t)) rank_if ();

    partial_permutation_ranker #(
        .UNIVERSE_SIZE(UNIVERSE),
        .MAX_LENGTH   (MAX_LEN)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .elements(elem_if),
        .ranks   (rank_if)
    );

    ppr_pkg::ppr_elem_t   pending_elems [$];
    ppr_pkg::ppr_result_t expected_ranks [$];
    ppr_pkg::ppr_result_t rank_want;
    int          queued_total;
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    // Lehmer-code state of the sequence in flight
    logic [15:0] seen_values;
    logic [31:0] partial_rank;
    logic [3:0]  elem_count;
    logic        too_long;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("partial_permutation_ranker verification failed");
        $finish;
    end

    function automatic void rank_element(input ppr_pkg::ppr_elem_t req);
        logic [15:0] below;
        logic [31:0] smaller_free;
        logic [31:0] factor;
        ppr_pkg::ppr_result_t res;
        if (elem_count >= LEN_LIMIT)
        begin
            too_long = 1'b1;
        end
        else
        begin
            // every 4-bit value lies inside a 16-value universe
            below        = (16'd1 << req.element_value) - 16'd1;
            smaller_free = $countones(below & ~seen_values);
            factor       = UNIVERSE - elem_count;
            partial_rank = partial_rank * factor + smaller_free;
            seen_values[req.element_value] = 1'b1;
            elem_count   = elem_count + 4'd1;
        end
        if (req.is_last)
        begin
            res.perm_rank    = too_long ? '0 : partial_rank;
            res.length_error = too_long;
            expected_ranks.push_back(res);
            seen_values  = '0;
            partial_rank = '0;
            elem_count   = '0;
            too_long     = 1'b0;
        end
    endfunction

    task automatic queue_element(input logic [3:0] value, input logic last);
        ppr_pkg::ppr_elem_t req;
        req.element_value = value;
        req.is_last       = last;
        pending_elems.push_back(req);
        queued_total++;
    endtask

    task automatic queue_sequence(input seq_kind_e kind);
        logic [3:0] pool [16];
        logic [3:0] swap;
        int len;
        int j;
        for (int k = 0; k < 16; k++)
        begin
            pool[k] = k[3:0];
        end
        unique case (kind)
            SEQ_PERM:     len = $urandom_range(9, 1);
            SEQ_OVERLONG: len = $urandom_range(16, 10);
            default:      len = $urandom_range(12, 1);
        endcase
        for (int k = 0; k < len; k++)
        begin
            if (kind == SEQ_NOISE)
            begin
                queue_element(4'($urandom_range(15)), k == len - 1);
            end
            else
            begin
                // partial shuffle keeps the values distinct
                j       = $urandom_range(15, k);
                swap    = pool[k];
                pool[k] = pool[j];
                pool[j] = swap;
                queue_element(pool[k], k == len - 1);
            end
        end
    endtask

    // element driver: hold a request until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_if.valid   <= 1'b0;
            elem_if.payload <= '0;
        end
        else
        begin
            if (elem_if.valid && elem_if.ready)
            begin
                rank_element(elem_if.payload);
                void'(pending_elems.pop_front());
            end
            if (elem_if.valid && !elem_if.ready)
            begin
                // hold
            end
            else if (pending_elems.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                elem_if.valid   <= 1'b1;
                elem_if.payload <= pending_elems[0];
            end
            else
            begin
                elem_if.valid <= 1'b0;
            end
        end
    end

    // rank monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_if.ready <= 1'b0;
        end
        else
        begin
            if (rank_if.valid && rank_if.ready)
            begin
                if (expected_ranks.size() == 0)
                begin
                    $display("%0t: unexpected rank: expected none, actual rank %0d error %0b",
                             $realtime, rank_if.payload.perm_rank,
                             rank_if.payload.length_error);
                    mismatch_count++;
                end
                else
                begin
                    rank_want = expected_ranks.pop_front();
                    if (rank_if.payload.perm_rank !== rank_want.perm_rank)
                    begin
                        $display("%0t: perm_rank mismatch: expected %0d, actual %0d",
                                 $realtime, rank_want.perm_rank, rank_if.payload.perm_rank);
                        mismatch_count++;
                    end
                    if (rank_if.payload.length_error !== rank_want.length_error)
                    begin
                        $display("%0t: length_error mismatch: expected %0b, actual %0b",
                                 $realtime, rank_want.length_error,
                                 rank_if.payload.length_error);
                        mismatch_count++;
                    end
                end
            end
            rank_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int phase_goal;
        int roll;
        rst_n           = 1'b0;
        elem_if.valid   = 1'b0;
        elem_if.payload = '0;
        rank_if.ready   = 1'b0;
        seen_values     = '0;
        partial_rank    = '0;
        elem_count      = '0;
        too_long        = 1'b0;
        queued_total    = 0;
        mismatch_count  = 0;
        send_idle_pct   = 36;
        recv_idle_pct   = 75;

        // single top value
        queue_element(4'd15, 1'b1);
        // longest sequence, descending: highest possible rank
        for (int v = 15; v >= 7; v--)
        begin
            queue_element(v[3:0], v == 7);
        end
        // ascending: rank zero
        for (int v = 0; v < 3; v++)
        begin
            queue_element(v[3:0], v == 2);
        end
        // repeated value
        queue_element(4'd5, 1'b0);
        queue_element(4'd5, 1'b1);
        // one element past the length bound
        for (int v = 9; v >= 0; v--)
        begin
            queue_element(v[3:0], v == 0);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++)
        begin
            @(negedge clk);
            if (phase == 1)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 36;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            phase_goal = queued_total + PHASE_ITEMS;
            while (queued_total < phase_goal)
            begin
                roll = $urandom_range(99);
                if (roll < 80)
                    queue_sequence(SEQ_PERM);
                else if (roll < 90)
                    queue_sequence(SEQ_OVERLONG);
                else
                    queue_sequence(SEQ_NOISE);
            end
            while (pending_elems.size() > 0) @(negedge clk);
        end

        while (expected_ranks.size() > 0) @(negedge clk);
        repeat (8) @(negedge clk);

        if (mismatch_count == 0)
            $display("partial_permutation_ranker verification clean");
        else
            $display("partial_permutation_ranker verification failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ppr_pkg.sv
hw/rtl/ppr_stream_if.sv
hw/rtl/ppr_rank_core.sv
hw/rtl/partial_permutation_ranker.sv
test/tb.sv
